[hw/rtl/tcw_pkg.sv]
// Shared types, codes and defaults of the text console character writer.
package tcw_pkg;

  // Default geometry
  localparam int unsigned DEF_COLUMNS   = 80;
  localparam int unsigned DEF_ROWS      = 25;
  localparam int unsigned DEF_TAB_WIDTH = 8;

  // Fixed field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ADDR_W    = 11;
  localparam int unsigned CURSOR_W  = 11;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned COLOUR_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd1;

  // Register reset values
  localparam logic [COLOUR_W-1:0] RST_BACKGROUND = 4'h0;
  localparam logic [COLOUR_W-1:0] RST_FOREGROUND = 4'hF;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST_PRN  = 8'h7F;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_GLYPH,
    CMD_BS,
    CMD_TAB,
    CMD_CR,
    CMD_LF,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] glyph;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_location;
    logic [CELL_W-1:0]   read_data;
    logic                scrolled;
  } res_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } back_state_t;

endpackage

[hw/rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/tcw_fifo.sv]
// Two-entry word queue used between the front, the back and the result port.
module tcw_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hw/rtl/tcw_front.sv]
// Front end: accepts input words, classifies them and queues commands.
module tcw_front import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = DEF_COLUMNS,
  parameter int unsigned ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hold,
  input  logic              in_push,
  output logic              in_full,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ADDR_W-1:0] in_read_address,
  input  logic              cmd_pop,
  output logic              cmd_empty,
  output cmd_t              cmd
);

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  cmd_t cmd_in;
  logic q_full;
  logic q_push;

  // Hold off input while the store is being cleared after reset
  assign in_full = q_full || hold;
  assign q_push  = in_push && !in_full;

  // Classify the word
  always_comb begin
    cmd_in.glyph = in_char_code;
    cmd_in.addr  = in_read_address;
    case (in_operation)
      OP_PUT: begin
        if (in_char_code == CH_BACKSPACE) begin
          cmd_in.kind = CMD_BS;
        end else if (in_char_code == CH_TAB) begin
          cmd_in.kind = CMD_TAB;
        end else if (in_char_code == CH_CR) begin
          cmd_in.kind = CMD_CR;
        end else if (in_char_code == CH_LF) begin
          cmd_in.kind = CMD_LF;
        end else if (in_char_code >= CH_SPACE && in_char_code <= CH_LAST_PRN) begin
          cmd_in.kind = CMD_GLYPH;
        end else begin
          cmd_in.kind = CMD_NOP;
        end
      end
      OP_CLEAR: cmd_in.kind = CMD_CLEAR;
      OP_READ: begin
        // An address past the store reads as zero, which a no-op reports
        if (32'(in_read_address) < CELL_COUNT) begin
          cmd_in.kind = CMD_READ;
        end else begin
          cmd_in.kind = CMD_NOP;
        end
      end
      default: cmd_in.kind = CMD_NOP;
    endcase
  end

  tcw_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (cmd_in),
    .full      (q_full),
    .pop       (cmd_pop),
    .pop_data  (cmd),
    .empty     (cmd_empty)
  );

endmodule

[hw/rtl/tcw_back.sv]
// Back end: cursor, cell store sequencer (write, read, scroll, clear) and result queue.
module tcw_back import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = DEF_COLUMNS,
  parameter int unsigned ROWS      = DEF_ROWS,
  parameter int unsigned TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2*COLOUR_W-1:0] attr,
  input  logic                  cmd_empty,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  output logic                  init_busy,
  input  logic                  out_pop,
  output logic                  out_empty,
  output res_t                  res_out
);

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned CELL_AW    = $clog2(CELL_COUNT);
  localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int unsigned CW         = $clog2(COLUMNS);
  localparam int unsigned RW         = $clog2(ROWS);
  localparam int unsigned TCW        = $clog2(COLUMNS + TAB_WIDTH);
  localparam int unsigned LW         = (CNT_W > CURSOR_W) ? CNT_W : CURSOR_W;

  localparam logic [CNT_W-1:0] LAST_CELL     = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] END_CELL      = CNT_W'(CELL_COUNT);
  localparam logic [CNT_W-1:0] COL_STRIDE    = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] LAST_ROW_BASE = CNT_W'((ROWS - 1) * COLUMNS);
  localparam logic [RW-1:0]    LAST_ROW      = RW'(ROWS - 1);
  localparam logic [TCW-1:0]   COL_LIMIT     = TCW'(COLUMNS);

  back_state_t       state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]  sweep_r, sweep_nxt;
  logic              pend_r, pend_nxt;
  logic              fill_scroll_r, fill_scroll_nxt;
  logic [CELL_AW-1:0] dst_r, dst_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;

  logic [TCW-1:0]    tab_next [COLUMNS];
  logic [CELL_W-1:0] blank;
  logic              start;
  logic [TCW-1:0]    col_step;
  logic              wrap;
  logic [CW-1:0]     col_fin;
  logic              inc_row;
  logic              put_scroll;
  logic [CNT_W-1:0]  base_put;
  logic [RW-1:0]     row_put;
  logic [CW-1:0]     wcol;
  logic [CURSOR_W-1:0] cursor_now;
  logic [CURSOR_W-1:0] cursor_put;

  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_AW-1:0] ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  logic res_push;
  logic res_full;
  res_t res_in;

  // Tab stop for each column
  for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
    assign tab_next[g] = TCW'((g / TAB_WIDTH + 1) * TAB_WIDTH);
  end

  assign blank     = {attr, CH_SPACE};
  assign init_busy = (state_r == ST_INIT);
  assign start     = (state_r == ST_IDLE) && !cmd_empty && !res_full;

  // Cursor movement for a put command
  always_comb begin
    case (cmd.kind)
      CMD_BS:    col_step = (col_r != '0) ? TCW'(col_r) - TCW'(1) : TCW'(col_r);
      CMD_TAB:   col_step = tab_next[col_r];
      CMD_CR:    col_step = '0;
      CMD_LF:    col_step = '0;
      CMD_GLYPH: col_step = TCW'(col_r) + TCW'(1);
      default:   col_step = TCW'(col_r);
    endcase
  end

  assign wrap       = (col_step >= COL_LIMIT);
  assign col_fin    = wrap ? '0 : CW'(col_step);
  assign inc_row    = (cmd.kind == CMD_LF) || wrap;
  assign put_scroll = inc_row && (row_r == LAST_ROW);
  assign base_put   = (inc_row && !put_scroll) ? base_r + COL_STRIDE : base_r;
  assign row_put    = (inc_row && !put_scroll) ? row_r + RW'(1) : row_r;
  assign wcol       = (cmd.kind == CMD_BS) ? col_r - CW'(1) : col_r;
  assign cursor_now = CURSOR_W'(LW'(base_r) + LW'(col_r));
  assign cursor_put = CURSOR_W'(LW'(base_put) + LW'(col_fin));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd.kind)
            CMD_CLEAR: state_nxt = ST_FILL;
            CMD_READ:  state_nxt = ST_READ;
            default:   state_nxt = put_scroll ? ST_SCROLL : ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_SCROLL: begin
        if (sweep_r == END_CELL) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sweep_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Store accesses, cursor updates and results
  always_comb begin
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = sweep_r[CELL_AW-1:0];
    ram_wdata       = '0;
    ram_raddr       = sweep_r[CELL_AW-1:0];
    res_push        = 1'b0;
    res_in          = '0;
    col_nxt         = col_r;
    row_nxt         = row_r;
    base_nxt        = base_r;
    sweep_nxt       = sweep_r;
    pend_nxt        = pend_r;
    fill_scroll_nxt = fill_scroll_r;
    dst_nxt         = dst_r;
    fill_val_nxt    = fill_val_r;
    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        sweep_nxt = sweep_r + CNT_W'(1);
      end
      ST_IDLE: begin
        if (start) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_CLEAR: begin
              col_nxt         = '0;
              row_nxt         = '0;
              base_nxt        = '0;
              sweep_nxt       = '0;
              fill_val_nxt    = blank;
              fill_scroll_nxt = 1'b0;
            end
            CMD_READ: begin
              ram_raddr = CELL_AW'(cmd.addr);
            end
            default: begin
              ram_we    = (cmd.kind == CMD_GLYPH) || (cmd.kind == CMD_BS && col_r != '0);
              ram_waddr = CELL_AW'(base_r + CNT_W'(wcol));
              ram_wdata = (cmd.kind == CMD_GLYPH) ? {attr, cmd.glyph} : blank;
              col_nxt   = col_fin;
              row_nxt   = row_put;
              base_nxt  = base_put;
              if (put_scroll) begin
                sweep_nxt       = COL_STRIDE;
                pend_nxt        = 1'b0;
                fill_val_nxt    = blank;
                fill_scroll_nxt = 1'b1;
              end else begin
                res_push               = 1'b1;
                res_in.cursor_location = cursor_put;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        res_push               = 1'b1;
        res_in.cursor_location = cursor_now;
        res_in.read_data       = ram_rdata;
      end
      ST_SCROLL: begin
        // Read a line ahead, write the word read last cycle one line up
        ram_we    = pend_r;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        pend_nxt  = (sweep_r != END_CELL);
        dst_nxt   = CELL_AW'(sweep_r - COL_STRIDE);
        sweep_nxt = (sweep_r != END_CELL) ? sweep_r + CNT_W'(1) : LAST_ROW_BASE;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_val_r;
        sweep_nxt = sweep_r + CNT_W'(1);
        if (sweep_r == LAST_CELL) begin
          res_push               = 1'b1;
          res_in.cursor_location = cursor_now;
          res_in.scrolled        = fill_scroll_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      col_r         <= '0;
      row_r         <= '0;
      base_r        <= '0;
      sweep_r       <= '0;
      pend_r        <= 1'b0;
      fill_scroll_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      base_r        <= base_nxt;
      sweep_r       <= sweep_nxt;
      pend_r        <= pend_nxt;
      fill_scroll_r <= fill_scroll_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dst_r      <= dst_nxt;
    fill_val_r <= fill_val_nxt;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  tcw_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_out),
    .empty     (out_empty)
  );

  // A finished command always finds room in the result queue
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // The cursor column stays on the screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < COLUMNS)
    else $error("cursor column out of range");

  // The row base tracks the row
  a_base_row: assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) == 32'(row_r) * COLUMNS)
    else $error("row base out of step with row");

  // The scroll sweep stays between the second line and the end of the store
  a_scroll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL) |-> (sweep_r >= COL_STRIDE && sweep_r <= END_CELL))
    else $error("scroll sweep out of range");

endmodule

[hw/rtl/text_console_character_writer.sv]
// Top level of the text console character writer: configuration and front/back wiring.
//
// A COLUMNS x ROWS store of 16-bit text cells (attribute byte over character byte) with a
// cursor. Each input word yields one result word with the cursor location after it. After
// reset the store is cleared to zero while in_full stays high; configuration writes are
// taken at any time. A put that only writes one cell or moves the cursor is done in the
// idle state of the back end, a read passes through a read state, a put that scrolls copies
// every line but the first one line up and then fills the last line, and a clear fills the
// whole store; every cell is rewritten once through the store's single write port. A two-word
// command queue in front and a two-word result queue behind let input and output stall independently.
module text_console_character_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = DEF_COLUMNS,
  parameter int unsigned ROWS      = DEF_ROWS,
  parameter int unsigned TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [ADDR_W-1:0]    in_read_address,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [CURSOR_W-1:0]  out_cursor_location,
  output logic [CELL_W-1:0]    out_read_data,
  output logic                 out_scrolled,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]  cfg_data
);

  logic [COLOUR_W-1:0] background_r;
  logic [COLOUR_W-1:0] foreground_r;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                init_busy;
  cmd_t                cmd;
  res_t                res_out;

  assign cfg_ready = 1'b1;

  // Colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      background_r <= RST_BACKGROUND;
      foreground_r <= RST_FOREGROUND;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BACKGROUND: background_r <= cfg_data;
        REG_FOREGROUND: foreground_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .hold            (init_busy),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_char_code    (in_char_code),
    .in_read_address (in_read_address),
    .cmd_pop         (cmd_pop),
    .cmd_empty       (cmd_empty),
    .cmd             (cmd)
  );

  tcw_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      ({background_r, foreground_r}),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .init_busy (init_busy),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res_out   (res_out)
  );

  assign out_cursor_location = res_out.cursor_location;
  assign out_read_data       = res_out.read_data;
  assign out_scrolled        = res_out.scrolled;

endmodule
